FILE: hdl/bstk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstk_pkg
// Types and codes shared by the bounded stack controller, datapath and top.
// ----------------------------------------------------------------------------
package bstk_pkg;

  // operation codes
  localparam logic [1:0] FUNC_PUSH    = 2'd0;
  localparam logic [1:0] FUNC_POP     = 2'd1;
  localparam logic [1:0] FUNC_REVERSE = 2'd2;
  localparam logic [1:0] FUNC_SORTED  = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  localparam logic signed [31:0] VALUE_NONE      = 32'sd0;
  localparam logic signed [31:0] VALUE_UNDERFLOW = -32'sd1;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value_in;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic [5:0]         fill_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_OUT,
    S_REV_RA,
    S_REV_RB,
    S_REV_WLO,
    S_REV_WHI,
    S_SORT_CMP,
    S_SORT_PLACE
  } state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_PUSH,
    DP_OVF,
    DP_UNF,
    DP_POP_RD,
    DP_POP_OUT,
    DP_REV_INIT,
    DP_REV_RA,
    DP_REV_RB,
    DP_REV_WLO,
    DP_REV_WHI,
    DP_DONE,
    DP_SORT_INIT,
    DP_SORT_CMP,
    DP_SORT_PLACE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       empty;
    logic       full;
    logic       count_le1;
    logic       rev_more;
    logic       sort_lt;
    logic       sort_last;
  } dp_stat_t;

endpackage

FILE: hdl/bstk_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstk_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/bstk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstk_ctrl
// Sequencer for the stack operations; drives one datapath command per cycle.
// ----------------------------------------------------------------------------
module bstk_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  bstk_pkg::dp_stat_t  stat,
  output bstk_pkg::ctrl_cmd_t cmd
);

  bstk_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bstk_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bstk_pkg::S_IDLE: begin
        if (start) state_next = bstk_pkg::S_DISPATCH;
      end
      bstk_pkg::S_DISPATCH: begin
        unique case (stat.func)
          bstk_pkg::FUNC_PUSH: state_next = bstk_pkg::S_IDLE;
          bstk_pkg::FUNC_POP: begin
            state_next = stat.empty ? bstk_pkg::S_IDLE : bstk_pkg::S_POP_OUT;
          end
          bstk_pkg::FUNC_REVERSE: begin
            state_next = stat.count_le1 ? bstk_pkg::S_IDLE : bstk_pkg::S_REV_RA;
          end
          bstk_pkg::FUNC_SORTED: begin
            state_next = (stat.full || stat.empty) ? bstk_pkg::S_IDLE
                                                   : bstk_pkg::S_SORT_CMP;
          end
          default: state_next = bstk_pkg::S_IDLE;
        endcase
      end
      bstk_pkg::S_POP_OUT: state_next = bstk_pkg::S_IDLE;
      bstk_pkg::S_REV_RA: begin
        state_next = stat.rev_more ? bstk_pkg::S_REV_RB : bstk_pkg::S_IDLE;
      end
      bstk_pkg::S_REV_RB:  state_next = bstk_pkg::S_REV_WLO;
      bstk_pkg::S_REV_WLO: state_next = bstk_pkg::S_REV_WHI;
      bstk_pkg::S_REV_WHI: state_next = bstk_pkg::S_REV_RA;
      bstk_pkg::S_SORT_CMP: begin
        if (!stat.sort_lt) begin
          state_next = bstk_pkg::S_IDLE;
        end else if (stat.sort_last) begin
          state_next = bstk_pkg::S_SORT_PLACE;
        end
      end
      bstk_pkg::S_SORT_PLACE: state_next = bstk_pkg::S_IDLE;
      default: state_next = bstk_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = bstk_pkg::DP_NONE;
    busy   = 1'b1;
    unique case (state)
      bstk_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) cmd.op = bstk_pkg::DP_LOAD;
      end
      bstk_pkg::S_DISPATCH: begin
        unique case (stat.func)
          bstk_pkg::FUNC_PUSH: begin
            cmd.op = stat.full ? bstk_pkg::DP_OVF : bstk_pkg::DP_PUSH;
          end
          bstk_pkg::FUNC_POP: begin
            cmd.op = stat.empty ? bstk_pkg::DP_UNF : bstk_pkg::DP_POP_RD;
          end
          bstk_pkg::FUNC_REVERSE: begin
            cmd.op = stat.count_le1 ? bstk_pkg::DP_DONE : bstk_pkg::DP_REV_INIT;
          end
          bstk_pkg::FUNC_SORTED: begin
            // empty stack falls back to a plain push
            if (stat.full) begin
              cmd.op = bstk_pkg::DP_OVF;
            end else if (stat.empty) begin
              cmd.op = bstk_pkg::DP_PUSH;
            end else begin
              cmd.op = bstk_pkg::DP_SORT_INIT;
            end
          end
          default: cmd.op = bstk_pkg::DP_NONE;
        endcase
      end
      bstk_pkg::S_POP_OUT: cmd.op = bstk_pkg::DP_POP_OUT;
      bstk_pkg::S_REV_RA: begin
        cmd.op = stat.rev_more ? bstk_pkg::DP_REV_RA : bstk_pkg::DP_DONE;
      end
      bstk_pkg::S_REV_RB:     cmd.op = bstk_pkg::DP_REV_RB;
      bstk_pkg::S_REV_WLO:    cmd.op = bstk_pkg::DP_REV_WLO;
      bstk_pkg::S_REV_WHI:    cmd.op = bstk_pkg::DP_REV_WHI;
      bstk_pkg::S_SORT_CMP:   cmd.op = bstk_pkg::DP_SORT_CMP;
      bstk_pkg::S_SORT_PLACE: cmd.op = bstk_pkg::DP_SORT_PLACE;
      default:                cmd.op = bstk_pkg::DP_NONE;
    endcase
  end

endmodule

FILE: hdl/bstk_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstk_dp
// Stack datapath: entry RAM, fill count, walk pointers and result register.
// ----------------------------------------------------------------------------
module bstk_dp #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  bstk_pkg::req_t      req,
  input  bstk_pkg::ctrl_cmd_t cmd,
  output bstk_pkg::dp_stat_t  stat,
  output logic                strobe,
  output bstk_pkg::rsp_t      result
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  logic [1:0]         func_q;
  logic signed [31:0] value_q;
  logic [CNT_W-1:0]   count, count_next;
  logic [ADDR_W-1:0]  lo, lo_next, hi, hi_next, p, p_next;
  logic signed [31:0] tmp, tmp_next;
  logic [ADDR_W-1:0]  count_lo;
  logic [CNT_W+5:0]   count_ext;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;
  logic signed [31:0] rd_val;

  logic               res_load;
  logic signed [31:0] res_value;
  logic [1:0]         res_status;

  assign count_lo  = count[ADDR_W-1:0];
  assign count_ext = {6'd0, count_next};
  assign rd_val    = $signed(ram_rdata);

  bstk_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign stat.func      = func_q;
  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CNT_W'(STACK_DEPTH));
  assign stat.count_le1 = (count <= CNT_W'(1));
  assign stat.rev_more  = (lo < hi);
  assign stat.sort_lt   = (rd_val < value_q);
  assign stat.sort_last = (p == ADDR_W'(1));

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = lo;
    ram_wdata  = value_q;
    ram_raddr  = lo;
    count_next = count;
    lo_next    = lo;
    hi_next    = hi;
    p_next     = p;
    tmp_next   = tmp;
    res_load   = 1'b0;
    res_value  = bstk_pkg::VALUE_NONE;
    res_status = bstk_pkg::STAT_OK;
    unique case (cmd.op)
      bstk_pkg::DP_NONE, bstk_pkg::DP_LOAD: begin
      end
      bstk_pkg::DP_PUSH: begin
        ram_we     = 1'b1;
        ram_waddr  = count_lo;
        count_next = count + CNT_W'(1);
        res_load   = 1'b1;
      end
      bstk_pkg::DP_OVF: begin
        res_load   = 1'b1;
        res_status = bstk_pkg::STAT_OVERFLOW;
      end
      bstk_pkg::DP_UNF: begin
        res_load   = 1'b1;
        res_value  = bstk_pkg::VALUE_UNDERFLOW;
        res_status = bstk_pkg::STAT_UNDERFLOW;
      end
      bstk_pkg::DP_POP_RD: begin
        ram_raddr  = count_lo - ADDR_W'(1);
        count_next = count - CNT_W'(1);
      end
      bstk_pkg::DP_POP_OUT: begin
        res_load  = 1'b1;
        res_value = rd_val;
      end
      bstk_pkg::DP_REV_INIT: begin
        lo_next = '0;
        hi_next = count_lo - ADDR_W'(1);
      end
      bstk_pkg::DP_REV_RA: begin
        ram_raddr = lo;
      end
      bstk_pkg::DP_REV_RB: begin
        ram_raddr = hi;
        tmp_next  = rd_val;
      end
      bstk_pkg::DP_REV_WLO: begin
        ram_we    = 1'b1;
        ram_waddr = lo;
        ram_wdata = ram_rdata;
      end
      bstk_pkg::DP_REV_WHI: begin
        ram_we    = 1'b1;
        ram_waddr = hi;
        ram_wdata = tmp;
        lo_next   = lo + ADDR_W'(1);
        hi_next   = hi - ADDR_W'(1);
      end
      bstk_pkg::DP_DONE: begin
        res_load = 1'b1;
      end
      bstk_pkg::DP_SORT_INIT: begin
        p_next    = count_lo;
        ram_raddr = count_lo - ADDR_W'(1);
      end
      bstk_pkg::DP_SORT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = p;
        if (rd_val < value_q) begin
          // smaller entry moves up one place, prefetch the next one down
          ram_wdata = ram_rdata;
          p_next    = p - ADDR_W'(1);
          ram_raddr = p - ADDR_W'(2);
        end else begin
          count_next = count + CNT_W'(1);
          res_load   = 1'b1;
        end
      end
      bstk_pkg::DP_SORT_PLACE: begin
        ram_we     = 1'b1;
        ram_waddr  = p;
        count_next = count + CNT_W'(1);
        res_load   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      lo     <= '0;
      hi     <= '0;
      p      <= '0;
      strobe <= 1'b0;
    end else begin
      count  <= count_next;
      lo     <= lo_next;
      hi     <= hi_next;
      p      <= p_next;
      strobe <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    tmp <= tmp_next;
    if (cmd.op == bstk_pkg::DP_LOAD) begin
      func_q  <= req.func;
      value_q <= req.value_in;
    end
    if (res_load) begin
      result.value_out  <= res_value;
      result.status     <= res_status;
      result.fill_count <= count_ext[5:0];
    end
  end

endmodule

FILE: hdl/bounded_stack_with_sorted_insert_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_stack_with_sorted_insert_core
// Bounded stack of signed words with push, pop, reverse and sorted push.
// ----------------------------------------------------------------------------
// sequence: request captured in idle; push, overflow, underflow, short reverse
//   reply at dispatch; pop reads then replies; reverse reads lo, hi, writes lo, hi
//   per pair; sorted push moves smaller entries up one per cycle via the RAM port
// throughput: busy drops as the result is registered, so a new request may
//   arrive while the strobe shows; the receiver cannot stall
// reset: fill count cleared, entry RAM left as is (no clearing pass)
module bounded_stack_with_sorted_insert_core #(
  parameter int STACK_DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  bstk_pkg::req_t req,
  output logic           strobe,
  output bstk_pkg::rsp_t result
);

  bstk_pkg::ctrl_cmd_t cmd;
  bstk_pkg::dp_stat_t  stat;

  bstk_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  bstk_dp #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .cmd   (cmd),
    .stat  (stat),
    .strobe(strobe),
    .result(result)
  );

endmodule

FILE: dv/tb_bounded_stack_with_sorted_insert_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_stack_with_sorted_insert_core
// Self-checking bench for the bounded stack. A driver feeds requests from a
// queue and predicts each reply on a shadow copy of the stack; a monitor
// compares every strobed reply with the oldest prediction, field by field.
// Directed corner cases come first, then randomised fill, drain and mixed
// sequences under several sender idle profiles.
// ----------------------------------------------------------------------------
module tb_bounded_stack_with_sorted_insert_core;

  localparam int          STACK_DEPTH   = 32;
  localparam int          RANDOM_ITEMS  = 1625;
  localparam int          SETTLE_CYCLES = 100;
  localparam longint      CYCLE_LIMIT   = 1000000;

  typedef struct {
    bstk_pkg::req_t req;
    int unsigned    idle_pct;
    bit             drain;
  } op_item_t;

  typedef struct {
    bstk_pkg::rsp_t  rsp;
    longint unsigned accept_cyc;
  } reply_due_t;

  logic           clk   = 1'b0;
  logic           rst   = 1'b1;
  logic           start = 1'b0;
  bstk_pkg::req_t req   = '0;
  logic           busy;
  logic           strobe;
  bstk_pkg::rsp_t result;

  op_item_t   op_queue[$];
  reply_due_t reply_due_q[$];

  logic signed [31:0] shadow_stack [STACK_DEPTH];
  int unsigned        shadow_fill = 0;

  longint unsigned cyc      = 0;
  longint unsigned n_issued = 0;
  longint unsigned n_done   = 0;
  int              fault_count = 0;

  bounded_stack_with_sorted_insert_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .strobe(strobe),
    .result(result)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  always @(posedge clk) begin
    if (cyc >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // applies one request to the shadow stack and returns the reply it earns
  function automatic bstk_pkg::rsp_t apply_to_shadow(bstk_pkg::req_t r);
    bstk_pkg::rsp_t     rsp;
    int unsigned        pos;
    logic signed [31:0] tmp;
    rsp.value_out = bstk_pkg::VALUE_NONE;
    rsp.status    = bstk_pkg::STAT_OK;
    case (r.func)
      bstk_pkg::FUNC_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          rsp.status = bstk_pkg::STAT_OVERFLOW;
        end else begin
          shadow_stack[shadow_fill] = r.value_in;
          shadow_fill++;
        end
      end
      bstk_pkg::FUNC_POP: begin
        if (shadow_fill == 0) begin
          rsp.status    = bstk_pkg::STAT_UNDERFLOW;
          rsp.value_out = bstk_pkg::VALUE_UNDERFLOW;
        end else begin
          shadow_fill--;
          rsp.value_out = shadow_stack[shadow_fill];
        end
      end
      bstk_pkg::FUNC_REVERSE: begin
        for (int unsigned i = 0; i < shadow_fill / 2; i++) begin
          tmp = shadow_stack[i];
          shadow_stack[i] = shadow_stack[shadow_fill - 1 - i];
          shadow_stack[shadow_fill - 1 - i] = tmp;
        end
      end
      default: begin
        if (shadow_fill >= STACK_DEPTH) begin
          rsp.status = bstk_pkg::STAT_OVERFLOW;
        end else begin
          // smaller entries on top stay above the new value
          pos = shadow_fill;
          while (pos > 0 && shadow_stack[pos - 1] < r.value_in) pos--;
          for (int unsigned i = shadow_fill; i > pos; i--)
            shadow_stack[i] = shadow_stack[i - 1];
          shadow_stack[pos] = r.value_in;
          shadow_fill++;
        end
      end
    endcase
    rsp.fill_count = shadow_fill[5:0];
    return rsp;
  endfunction

  // driver
  always @(posedge clk) begin : drive
    bit              fire;
    bit              nxt_start;
    longint unsigned issued_now;
    op_item_t        head;
    reply_due_t      due;
    if (!rst) begin
      fire       = start && !busy;
      issued_now = n_issued + fire;
      if (fire) begin
        due.rsp        = apply_to_shadow(req);
        due.accept_cyc = cyc;
        reply_due_q.push_back(due);
        n_issued <= issued_now;
      end
      if (!start || fire) begin
        nxt_start = 1'b0;
        if (op_queue.size() != 0) begin
          head = op_queue[0];
          if (head.drain) begin
            // hold off until every outstanding request has replied
            if (issued_now == n_done) void'(op_queue.pop_front());
          end else if ($urandom_range(99) >= head.idle_pct) begin
            void'(op_queue.pop_front());
            req       <= head.req;
            nxt_start = 1'b1;
          end
        end
        start <= nxt_start;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    reply_due_t due;
    if (!rst && strobe) begin
      // only requests accepted at an earlier edge can be replying now
      if (reply_due_q.size() == 0 || reply_due_q[0].accept_cyc >= cyc) begin
        $error("unexpected reply: value_out %0d status %0d fill_count %0d",
               result.value_out, result.status, result.fill_count);
        fault_count++;
      end else begin
        due = reply_due_q.pop_front();
        n_done <= n_done + 1;
        if (result.value_out !== due.rsp.value_out) begin
          $error("value_out: expected %0d, got %0d", due.rsp.value_out,
                 result.value_out);
          fault_count++;
        end
        if (result.status !== due.rsp.status) begin
          $error("status: expected %0d, got %0d", due.rsp.status, result.status);
          fault_count++;
        end
        if (result.fill_count !== due.rsp.fill_count) begin
          $error("fill_count: expected %0d, got %0d", due.rsp.fill_count,
                 result.fill_count);
          fault_count++;
        end
      end
    end
  end

  task automatic add_op(logic [1:0] func, logic signed [31:0] value,
                        int unsigned idle_pct);
    op_item_t item;
    item.req.func     = func;
    item.req.value_in = value;
    item.idle_pct     = idle_pct;
    item.drain        = 1'b0;
    op_queue.push_back(item);
  endtask

  task automatic add_drain();
    op_item_t item;
    item.req      = '0;
    item.idle_pct = 0;
    item.drain    = 1'b1;
    op_queue.push_back(item);
  endtask

  function automatic logic signed [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return $signed($urandom_range(16)) - 8;
    if (sel < 55) begin
      case ($urandom_range(3))
        0:       return 32'sh7fffffff;
        1:       return 32'sh80000000;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $signed($urandom);
  endfunction

  function automatic logic [1:0] pick_func(int unsigned mode);
    int unsigned sel;
    sel = $urandom_range(99);
    if (mode < 4) begin
      // fill run: mostly pushes, often running into a full stack
      if (sel < 45) return bstk_pkg::FUNC_PUSH;
      if (sel < 85) return bstk_pkg::FUNC_SORTED;
      if (sel < 90) return bstk_pkg::FUNC_POP;
      return bstk_pkg::FUNC_REVERSE;
    end
    if (mode < 7) begin
      // drain run: mostly pops, often running past empty
      if (sel < 70) return bstk_pkg::FUNC_POP;
      if (sel < 80) return bstk_pkg::FUNC_PUSH;
      if (sel < 90) return bstk_pkg::FUNC_SORTED;
      return bstk_pkg::FUNC_REVERSE;
    end
    return sel[1:0];
  endfunction

  initial begin : stimulus
    int unsigned idle_by_phase [4];
    int unsigned n_rand;
    int unsigned mode;
    int unsigned seg_len;
    int unsigned phase;
    int unsigned last_phase;

    idle_by_phase = '{0, 60, 0, 35};

    // directed corners
    add_op(bstk_pkg::FUNC_POP,     32'sd0, 0);          // underflow on empty
    add_op(bstk_pkg::FUNC_REVERSE, 32'sd0, 0);          // reverse of empty
    add_op(bstk_pkg::FUNC_SORTED,  32'sd5, 0);          // sorted push on empty
    add_op(bstk_pkg::FUNC_REVERSE, 32'sd0, 0);          // reverse of one entry
    add_op(bstk_pkg::FUNC_PUSH,    32'sh7fffffff, 0);
    add_op(bstk_pkg::FUNC_PUSH,    32'sh80000000, 0);
    add_op(bstk_pkg::FUNC_PUSH,    32'sd0, 0);
    add_op(bstk_pkg::FUNC_PUSH,    -32'sd1, 0);
    add_op(bstk_pkg::FUNC_SORTED,  32'sd3, 20);         // slides under several smaller
    add_op(bstk_pkg::FUNC_SORTED,  -32'sd1, 20);        // equal top stays below
    add_op(bstk_pkg::FUNC_SORTED,  32'sh7fffffff, 20);
    add_op(bstk_pkg::FUNC_SORTED,  32'sh80000000, 20);
    add_op(bstk_pkg::FUNC_REVERSE, 32'sd0, 20);
    add_op(bstk_pkg::FUNC_POP,     32'sd0, 20);
    add_op(bstk_pkg::FUNC_REVERSE, 32'sd0, 20);
    add_op(bstk_pkg::FUNC_POP,     32'sd0, 0);
    add_op(bstk_pkg::FUNC_PUSH,    32'sd5, 0);
    add_op(bstk_pkg::FUNC_SORTED,  32'sd5, 0);
    add_op(bstk_pkg::FUNC_SORTED,  32'sd6, 0);
    add_op(bstk_pkg::FUNC_REVERSE, 32'sd0, 0);
    add_op(bstk_pkg::FUNC_POP,     32'sd0, 0);
    add_op(bstk_pkg::FUNC_POP,     32'sd0, 0);
    add_op(bstk_pkg::FUNC_POP,     32'sd0, 0);
    add_drain();

    n_rand     = 0;
    last_phase = 0;
    while (n_rand < RANDOM_ITEMS) begin
      mode    = $urandom_range(9);
      seg_len = $urandom_range(4, 48);
      for (int unsigned k = 0; k < seg_len && n_rand < RANDOM_ITEMS; k++) begin
        phase = ((n_rand * 8) / RANDOM_ITEMS) % 4;
        if (phase != last_phase) add_drain();
        last_phase = phase;
        add_op(pick_func(mode), pick_value(), idle_by_phase[phase]);
        n_rand++;
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (op_queue.size() != 0 || start || n_done != n_issued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (reply_due_q.size() != 0) begin
      $error("%0d predicted replies never arrived", reply_due_q.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
